// ----- hw/rtl/bmhq_pkg.sv -----
// Shared constants, types and codes for the binary min-heap queue.
package bmhq_pkg;

    localparam int DEPTH  = 1024;
    localparam int KEY_W  = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    // Wide enough to hold 2*pos+2 for any heap position.
    localparam int CHILD_W = ADDR_W + 2;

    typedef enum logic {
        OP_INSERT  = 1'b0,
        OP_EXTRACT = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0] min_key;
        status_t          status;
        logic [CNT_W-1:0] count;
    } res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_EX_RD,
        S_EX_LAST,
        S_DN_RD,
        S_DN_CMP,
        S_DONE
    } state_t;

endpackage

// ----- hw/rtl/bmhq_ram.sv -----
// Generic synchronous RAM with one write port and two registered read ports.
module bmhq_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd0_addr,
    output logic [WIDTH-1:0] rd0_data,
    input  logic [AW-1:0]    rd1_addr,
    output logic [WIDTH-1:0] rd1_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd0_data <= mem[rd0_addr];
        rd1_data <= mem[rd1_addr];
    end

endmodule

// ----- hw/rtl/bmhq_ctrl.sv -----
// Heap sequencer: sift-up and sift-down over the key memory, with the element count.
module bmhq_ctrl
    import bmhq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  opcode_t                  in_opcode,
    input  logic signed [KEY_W-1:0]  in_key,
    output logic                     res_valid,
    input  logic                     res_ready,
    output res_t                     res
);

    state_t                    state_reg, state_next;
    logic [ADDR_W-1:0]         pos_reg, pos_next;
    logic signed [KEY_W-1:0]   key_reg, key_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    res_t                      res_reg, res_next;

    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    logic [KEY_W-1:0]          wr_data;
    logic [ADDR_W-1:0]         rd0_addr, rd1_addr;
    logic [KEY_W-1:0]          rd0_data, rd1_data;

    logic [ADDR_W-1:0]         parent;
    logic [CHILD_W-1:0]        left_c, right_c;
    logic                      take_right;
    logic signed [KEY_W-1:0]   child_key;
    logic [ADDR_W-1:0]         child_addr;

    bmhq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (KEY_W)
    ) u_ram (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd0_addr (rd0_addr),
        .rd0_data (rd0_data),
        .rd1_addr (rd1_addr),
        .rd1_data (rd1_data)
    );

    assign parent  = (pos_reg - ADDR_W'(1)) >> 1;
    assign left_c  = {1'b0, pos_reg, 1'b1};
    assign right_c = left_c + CHILD_W'(1);

    // Among equal children the left one wins; the right one only exists below the count.
    assign take_right = (right_c < CHILD_W'(cnt_reg))
                        && ($signed(rd1_data) < $signed(rd0_data));
    assign child_key  = take_right ? $signed(rd1_data) : $signed(rd0_data);
    assign child_addr = take_right ? right_c[ADDR_W-1:0] : left_c[ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        key_reg <= key_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        key_next   = key_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        in_ready   = 1'b0;
        res_valid  = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = pos_reg;
        wr_data    = key_reg;
        rd0_addr   = left_c[ADDR_W-1:0];
        rd1_addr   = right_c[ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    res_next.min_key = '0;
                    res_next.status  = ST_OK;
                    key_next         = in_key;
                    pos_next         = '0;
                    if (in_opcode == OP_INSERT)
                    begin
                        if (cnt_reg == CNT_W'(DEPTH))
                        begin
                            res_next.status = ST_FULL;
                            res_next.count  = cnt_reg;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            pos_next       = cnt_reg[ADDR_W-1:0];
                            cnt_next       = cnt_reg + CNT_W'(1);
                            res_next.count = cnt_reg + CNT_W'(1);
                            state_next     = S_UP_RD;
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            res_next.status = ST_EMPTY;
                            res_next.count  = '0;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            cnt_next       = cnt_reg - CNT_W'(1);
                            res_next.count = cnt_reg - CNT_W'(1);
                            state_next     = S_EX_RD;
                        end
                    end
                end
            end

            S_UP_RD:
            begin
                rd0_addr = parent;
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_UP_CMP;
                end
            end

            S_UP_CMP:
            begin
                // The parent moves down into the hole while the new key is smaller.
                wr_en = 1'b1;
                if (key_reg < $signed(rd0_data))
                begin
                    wr_data    = rd0_data;
                    pos_next   = parent;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_EX_RD:
            begin
                rd0_addr   = '0;
                rd1_addr   = cnt_reg[ADDR_W-1:0];
                state_next = S_EX_LAST;
            end

            S_EX_LAST:
            begin
                res_next.min_key = rd0_data;
                key_next         = $signed(rd1_data);
                pos_next         = '0;
                state_next       = (cnt_reg == '0) ? S_DONE : S_DN_RD;
            end

            S_DN_RD:
            begin
                if (left_c >= CHILD_W'(cnt_reg))
                begin
                    wr_en      = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DN_CMP;
                end
            end

            S_DN_CMP:
            begin
                // The smaller child moves up into the hole while it beats the held key.
                wr_en = 1'b1;
                if (child_key < key_reg)
                begin
                    wr_data    = child_key;
                    pos_next   = child_addr;
                    state_next = S_DN_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("element count beyond the heap depth");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_DONE) |-> !wr_en)
        else $error("memory written outside a sift");

    a_request_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
        else $error("accepted request did not start an operation");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status == ST_FULL) |-> (res.count == CNT_W'(DEPTH)))
        else $error("full status with a count below the depth");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.count == cnt_reg))
        else $error("reported count differs from the element count");

endmodule

// ----- hw/rtl/binary_min_heap_queue_top.sv -----
// Top level of the binary min-heap queue: stream ports and the result register.
// A min-heap priority queue of up to 1024 signed 32-bit keys held in one on-chip memory
// with two read ports. Each request (insert or extract-minimum) gives exactly one result
// carrying the extracted key, a status and the new count. Requests are handled one at a
// time: an insert moves its key up while it is smaller than the parent, and an extract
// moves the last key down from the root while a child is smaller. A request refused on
// an empty or full heap is answered without touching the memory. Each level of either
// walk waits on a registered read of the memory. A finished result waits in an output
// register, so the next request is taken while it is still unread. No clearing pass is
// needed after reset.
module binary_min_heap_queue_top
    import bmhq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // key [31:0]
    input  logic        s_tuser,   // opcode [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // min_key [31:0], count [42:32], zero [47:43]
    output logic [1:0]  m_tuser    // status [1:0]
);

    logic  res_valid;
    logic  res_ready;
    res_t  res;
    logic  out_valid_reg, out_valid_next;
    res_t  out_reg, out_next;

    bmhq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_opcode (opcode_t'(s_tuser)),
        .in_key    ($signed(s_tdata)),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_reg.count, out_reg.min_key};
    assign m_tuser  = out_reg.status;

endmodule

// ----- tb/binary_min_heap_queue_top_tb.sv -----
// Self-checking testbench for the binary min-heap queue: random and directed requests.
module binary_min_heap_queue_top_tb;
    import bmhq_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    // Keeps its own heap and the results that the block still owes.
    class heap_scoreboard;
        logic signed [KEY_W-1:0] slots [DEPTH];
        int unsigned             held;
        res_t                    owed_results [$];
        int                      errors;

        function void swap_slots(int unsigned a, int unsigned b);
            logic signed [KEY_W-1:0] t;
            t        = slots[a];
            slots[a] = slots[b];
            slots[b] = t;
        endfunction

        function void note_request(opcode_t op, logic signed [KEY_W-1:0] key);
            res_t        r;
            int unsigned pos;
            int unsigned up;
            int unsigned child;
            r        = '0;
            r.status = ST_OK;
            if (op == OP_INSERT)
            begin
                if (held >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    slots[held] = key;
                    pos         = held;
                    while (pos > 0)
                    begin
                        up = (pos - 1) / 2;
                        if (!(slots[pos] < slots[up]))
                            break;
                        swap_slots(pos, up);
                        pos = up;
                    end
                    held++;
                end
            end
            else if (held == 0)
                r.status = ST_EMPTY;
            else
            begin
                r.min_key = slots[0];
                held--;
                slots[0] = slots[held];
                pos      = 0;
                // The last key walks down over the remaining keys only; ties go left.
                forever
                begin
                    child = 2 * pos + 1;
                    if (child >= held)
                        break;
                    if (child + 1 < held && slots[child + 1] < slots[child])
                        child++;
                    if (!(slots[child] < slots[pos]))
                        break;
                    swap_slots(pos, child);
                    pos = child;
                end
            end
            r.count = CNT_W'(held);
            owed_results.push_back(r);
        endfunction

        function void check_result(logic [KEY_W-1:0] min_key, status_t status,
                                   logic [CNT_W-1:0] count);
            res_t want;
            if (owed_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected, got min_key %0d status %0d count %0d",
                         $time, $signed(min_key), status, count);
                return;
            end
            want = owed_results.pop_front();
            if (min_key !== want.min_key)
            begin
                errors++;
                $display("%0t: min_key expected %0d, got %0d",
                         $time, $signed(want.min_key), $signed(min_key));
            end
            if (status !== want.status)
            begin
                errors++;
                $display("%0t: status expected %0d, got %0d", $time, want.status, status);
            end
            if (count !== want.count)
            begin
                errors++;
                $display("%0t: count expected %0d, got %0d", $time, want.count, count);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;

    heap_scoreboard sb;
    int             gap_odds;      // one idle burst in this many draws (per request or receiver cycle); zero means none
    int             hold_cycles;   // long receiver hold-off, counted down by the receiver
    int             cycles;

    binary_min_heap_queue_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata[31:0], status_t'(m_tuser), m_tdata[42:32]);
    end

    // Receiver: random stall bursts, plus the long hold-off when one is asked for.
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
            begin
                stall_left = $urandom_range(1, 11) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000 + 32'($urandom_range(0, 3));
            1:       return 32'h7FFF_FFFF - 32'($urandom_range(0, 3));
            2, 3:    return 32'($urandom_range(0, 16)) - 32'd8;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(input opcode_t op, input logic [KEY_W-1:0] key);
        int gap;
        gap = (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) ? $urandom_range(1, 11) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= key;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(op, key);
    endtask

    // The key travels on extract requests too, where the block must ignore it.
    task automatic random_request(input int insert_pct);
        if ($urandom_range(0, 99) < insert_pct)
            send_request(OP_INSERT, pick_key());
        else
            send_request(OP_EXTRACT, $urandom);
    endtask

    initial
    begin
        sb          = new();
        cycles      = 0;
        gap_odds    = 4;
        hold_cycles = 0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        rst_n       = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Extremes, equal keys, and extracts on an empty heap at both ends.
        send_request(OP_EXTRACT, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 32'h7FFF_FFFF);
        send_request(OP_INSERT, 32'h8000_0000);
        send_request(OP_INSERT, 32'h0000_0000);
        send_request(OP_INSERT, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 32'h0000_0001);
        send_request(OP_INSERT, 32'h0000_0000);
        send_request(OP_INSERT, 32'h8000_0000);
        send_request(OP_INSERT, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 32'h0000_0005);
        repeat (9) send_request(OP_EXTRACT, $urandom);
        send_request(OP_EXTRACT, 32'h0000_0000);

        // Long receiver hold-off while requests keep coming, so the input backs up.
        gap_odds    = 0;
        hold_cycles = 400;
        repeat (12) random_request(80);

        for (int i = 0; i < 300; i++)
        begin
            gap_odds = (i < 150) ? 3 : 12;
            random_request(55);
        end

        // Drain past empty.
        gap_odds = 5;
        while (sb.held > 0)
            random_request(30);
        repeat (3) send_request(OP_EXTRACT, $urandom);

        gap_odds = 0;
        repeat (40) random_request(60);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.owed_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.errors == 0 && sb.owed_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
